@@ hw/rtl/frenet_to_cartesian_unit_assert.svh @@
// assertion macros for the frenet to cartesian unit
`ifndef FRENET_TO_CARTESIAN_UNIT_ASSERT_SVH
`define FRENET_TO_CARTESIAN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define F2C_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define F2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define F2C_ASSERT(label, clk, rst_n, prop, msg)
`define F2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/f2c_pkg.sv @@
// ----------------------------------------------------------------------------
// f2c_pkg
// shared types and constants of the frenet to cartesian unit
// ----------------------------------------------------------------------------
package f2c_pkg;

  localparam int unsigned MapDepthDef  = 256;
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned FieldBits    = 32;
  localparam int unsigned SegBits      = 8;
  localparam int unsigned CountBits    = 9;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_CONVERT = 1'b1
  } action_e;

  // one request as it crosses from the front part to the back part
  typedef struct packed {
    logic                 convert;
    logic [SegBits-1:0]   wp_index;
    logic [FieldBits-1:0] wp_arc;
    logic [FieldBits-1:0] wp_east;
    logic [FieldBits-1:0] wp_north;
    logic [FieldBits-1:0] pos_arc;
    logic [FieldBits-1:0] pos_lateral;
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN_ADDR,
    ST_SCAN_WAIT,
    ST_SCAN_CHK,
    ST_RD_P,
    ST_RD_PW,
    ST_RD_Q,
    ST_RD_QW,
    ST_DIFF,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } back_state_e;

endpackage

@@ hw/rtl/f2c_ram.sv @@
// ----------------------------------------------------------------------------
// f2c_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module f2c_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/f2c_front.sv @@
// ----------------------------------------------------------------------------
// f2c_front
// accepts requests and queues them for the back part
// ----------------------------------------------------------------------------
module f2c_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  f2c_pkg::req_t  in_req_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output f2c_pkg::req_t  q_req_o
);
  import f2c_pkg::*;

  `include "frenet_to_cartesian_unit_assert.svh"

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  req_t               slot_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]   fill_q, fill_d;
  logic               push, pop;

  assign in_ready_o = (fill_q != (PtrBits+1)'(QueueDepth));
  assign q_valid_o  = (fill_q != '0);
  assign q_req_o    = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrBits'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrBits'(1) : rd_ptr_q;
    fill_d   = fill_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // each request is stored whole; the back part picks the fields it needs
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_req_i;
    end
  end

  `F2C_ASSERT(a_fill_range, clk_i, rst_ni, fill_q <= (PtrBits+1)'(QueueDepth),
              "queue fill above depth")
  `F2C_ASSERT_NEXT(a_fill_push, clk_i, rst_ni, push && !pop, fill_q == $past(fill_q) + 1'b1,
                   "queue fill did not grow on push")
  `F2C_ASSERT(a_ptr_match, clk_i, rst_ni,
              (fill_q == '0 || fill_q == (PtrBits+1)'(QueueDepth)) == (wr_ptr_q == rd_ptr_q),
              "queue pointers disagree with fill")

endmodule

@@ hw/rtl/f2c_back.sv @@
// ----------------------------------------------------------------------------
// f2c_back
// map storage, segment scan, heading and projection of convert requests
// ----------------------------------------------------------------------------
module f2c_back #(
  parameter int unsigned MapDepth  = f2c_pkg::MapDepthDef,
  parameter int unsigned CoordBits = f2c_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  f2c_pkg::req_t                     q_req_i,
  input  logic [f2c_pkg::CountBits-1:0]     map_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [f2c_pkg::FieldBits-1:0]     cart_x_o,
  output logic [f2c_pkg::FieldBits-1:0]     cart_y_o,
  output logic [f2c_pkg::SegBits-1:0]       segment_o
);
  import f2c_pkg::*;

  `include "frenet_to_cartesian_unit_assert.svh"

  localparam int unsigned AddrBits = $clog2(MapDepth);
  localparam int unsigned CntBits  = AddrBits + 1;

  back_state_e state_q, state_d;

  req_t                 req_q;
  logic [CntBits-1:0]   count_q;
  logic [CntBits-1:0]   idx_q, idx_d;
  logic [AddrBits-1:0]  p_q, q_idx;
  logic                 ram_we;
  logic [AddrBits-1:0]  ram_addr;
  logic [FieldBits-1:0] arc_rd, east_rd, north_rd;

  logic signed [32:0] arc_p_q, east_p_q, north_p_q;
  logic signed [32:0] dx_q, dy_q;
  logic               sx_q, sy_q;
  logic [32:0]        ax_q, ay_q;
  logic               zero_q;
  logic [63:0]        sq_acc_q, rem_q;
  logic [31:0]        root_q;
  logic [5:0]         step_q;
  logic [31:0]        len_q;
  logic [62:0]        num_q, drem_q;
  logic [31:0]        quo_q;
  logic               div_y_q;
  logic [31:0]        uc_q;
  logic signed [31:0] c_q, n_q;
  logic signed [33:0] ds_q;
  logic [1:0]         mstep_q;
  logic signed [66:0] prod_q [4];
  logic signed [67:0] tx_q, ty_q;
  logic               out_valid_q;
  logic [FieldBits-1:0] cart_x_q, cart_y_q;
  logic [SegBits-1:0]   seg_q;

  f2c_ram #(.Width(FieldBits), .Depth(MapDepth)) u_arc_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(req_q.wp_arc), .rdata_o(arc_rd));
  f2c_ram #(.Width(FieldBits), .Depth(MapDepth)) u_east_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(req_q.wp_east), .rdata_o(east_rd));
  f2c_ram #(.Width(FieldBits), .Depth(MapDepth)) u_north_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(req_q.wp_north), .rdata_o(north_rd));

  logic load_ok;
  assign load_ok = ({{(32-SegBits){1'b0}}, req_q.wp_index} < 32'(MapDepth));

  always_comb begin
    q_idx = (32'(p_q) + 32'd1 >= 32'(count_q)) ? '0 : p_q + AddrBits'(1);
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = idx_q[AddrBits-1:0];
    case (state_q)
      ST_LOAD: begin
        ram_we   = load_ok;
        ram_addr = AddrBits'(req_q.wp_index);
      end
      ST_RD_P, ST_RD_PW: ram_addr = p_q;
      ST_RD_Q, ST_RD_QW: ram_addr = q_idx;
      default: ram_addr = idx_q[AddrBits-1:0];
    endcase
  end

  assign q_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = q_req_i.convert ? ST_SCAN_ADDR : ST_LOAD;
      ST_LOAD: state_d = ST_IDLE;
      ST_SCAN_ADDR: state_d = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if ($signed(req_q.pos_arc) > $signed(arc_rd) && idx_q + CntBits'(1) < count_q) begin
          idx_d   = idx_q + CntBits'(1);
          state_d = ST_SCAN_WAIT;
        end else begin
          state_d = ST_RD_P;
        end
      end
      ST_RD_P:   state_d = ST_RD_PW;
      ST_RD_PW:  state_d = ST_RD_Q;
      ST_RD_Q:   state_d = ST_RD_QW;
      ST_RD_QW:  state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_NORM;
      ST_NORM:   if (zero_q || (ax_q[32:30] == 3'b001 || ay_q[32:30] == 3'b001) &&
                     ax_q[32:31] == 2'b00 && ay_q[32:31] == 2'b00) state_d = ST_SQUARE;
      ST_SQUARE: state_d = zero_q ? ST_MUL : ST_SQRT;
      ST_SQRT:   if (step_q == 6'd31) state_d = ST_DIV;
      ST_DIV:    if (step_q == 6'd62 && div_y_q) state_d = ST_MUL;
      ST_MUL:    if (mstep_q == 2'd3) state_d = ST_SUM;
      ST_SUM:    state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      else if (state_q == ST_OUT && !out_valid_q) out_valid_q <= 1'b1;
    end
  end

  // sums of Q16.46 products, rounded half up to Q16.16, added to the start waypoint, then saturated
  logic signed [67:0] rx, ry;
  logic signed [69:0] fx, fy;
  logic signed [69:0] hi_lim, lo_lim;
  assign rx = (tx_q + 68'sd536870912) >>> 30;
  assign ry = (ty_q + 68'sd536870912) >>> 30;
  assign fx = 70'(rx) + 70'(east_p_q);
  assign fy = 70'(ry) + 70'(north_p_q);
  assign hi_lim = (70'sd1 <<< (CoordBits-1)) - 70'sd1;
  assign lo_lim = -hi_lim - 70'sd1;

  logic [63:0] rem_sh;
  assign rem_sh = {rem_q[61:0], sq_acc_q[63:62]};

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) req_q <= q_req_i;
        count_q <= (map_count_i == '0) ? CntBits'(1) :
                   ({{(32-CountBits){1'b0}}, map_count_i} > 32'(MapDepth)) ?
                   CntBits'(MapDepth) : CntBits'(map_count_i);
        idx_q <= '0;
      end
      ST_SCAN_CHK: begin
        idx_q <= idx_d;
        if (!($signed(req_q.pos_arc) > $signed(arc_rd) && idx_q + CntBits'(1) < count_q)) begin
          if ($signed(req_q.pos_arc) > $signed(arc_rd)) p_q <= idx_q[AddrBits-1:0];
          else p_q <= (idx_q == '0) ? '0 : idx_q[AddrBits-1:0] - AddrBits'(1);
        end
      end
      ST_RD_PW: begin
        arc_p_q   <= 33'($signed(arc_rd));
        east_p_q  <= 33'($signed(east_rd));
        north_p_q <= 33'($signed(north_rd));
      end
      ST_RD_QW: begin
        dx_q <= 33'($signed(east_rd)) - east_p_q;
        dy_q <= 33'($signed(north_rd)) - north_p_q;
      end
      ST_DIFF: begin
        sx_q   <= dx_q[32];
        sy_q   <= dy_q[32];
        ax_q   <= dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
        ay_q   <= dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
        zero_q <= (dx_q == '0) && (dy_q == '0);
        ds_q   <= 34'($signed(req_q.pos_arc)) - 34'(arc_p_q);
      end
      ST_NORM: begin
        // one shift a cycle until the larger magnitude sits in [2^30, 2^31)
        if (!zero_q) begin
          if (ax_q[32:31] != 2'b00 || ay_q[32:31] != 2'b00) begin
            ax_q <= ax_q >> 1;
            ay_q <= ay_q >> 1;
          end else if (ax_q[30] == 1'b0 && ay_q[30] == 1'b0) begin
            ax_q <= ax_q << 1;
            ay_q <= ay_q << 1;
          end
        end
      end
      ST_SQUARE: begin
        sq_acc_q <= 64'(ax_q[30:0]) * 64'(ax_q[30:0]) + 64'(ay_q[30:0]) * 64'(ay_q[30:0]);
        rem_q    <= '0;
        root_q   <= '0;
        step_q   <= '0;
        mstep_q  <= '0;
        c_q      <= 32'sd1073741824;
        n_q      <= '0;
      end
      ST_SQRT: begin
        // restoring square root, one result bit a cycle
        sq_acc_q <= sq_acc_q << 2;
        if (rem_sh >= {29'd0, root_q, 2'b01}) begin
          rem_q  <= rem_sh - {29'd0, root_q, 2'b01};
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[30:0], 1'b0};
        end
        if (step_q == 6'd31) begin
          len_q   <= (rem_sh >= {29'd0, root_q, 2'b01}) ? {root_q[30:0], 1'b1} :
                                                          {root_q[30:0], 1'b0};
          step_q  <= '0;
          div_y_q <= 1'b0;
          num_q   <= {ax_q[30:0], 30'd0} + 63'({root_q[30:0], 1'b1} >> 1);
          drem_q  <= '0;
          quo_q   <= '0;
        end else begin
          step_q <= step_q + 6'd1;
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit a cycle over 63 numerator bits
        logic [63:0] r2;
        logic [31:0] qf;
        r2 = {drem_q, num_q[62]};
        qf = (r2 >= {32'd0, len_q}) ? {quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
        mstep_q <= '0;
        if (step_q == 6'd62) begin
          if (qf > 32'd1073741824) qf = 32'd1073741824;
          step_q <= '0;
          drem_q <= '0;
          quo_q  <= '0;
          if (!div_y_q) begin
            uc_q    <= qf;
            div_y_q <= 1'b1;
            num_q   <= {ay_q[30:0], 30'd0} + 63'(len_q >> 1);
          end else begin
            c_q <= sx_q ? -$signed(uc_q) : $signed(uc_q);
            n_q <= sy_q ? -$signed(qf) : $signed(qf);
          end
        end else begin
          step_q <= step_q + 6'd1;
          num_q  <= num_q << 1;
          quo_q  <= qf;
          if (r2 >= {32'd0, len_q}) drem_q <= 63'(r2 - {32'd0, len_q});
          else drem_q <= r2[62:0];
        end
      end
      ST_MUL: begin
        // one product a cycle, of at most 34x32 bits
        mstep_q <= mstep_q + 2'd1;
        case (mstep_q)
          2'd0: prod_q[0] <= 67'(ds_q) * 67'(c_q);
          2'd1: prod_q[1] <= 67'($signed(req_q.pos_lateral)) * 67'(n_q);
          2'd2: prod_q[2] <= 67'(ds_q) * 67'(n_q);
          2'd3: prod_q[3] <= 67'($signed(req_q.pos_lateral)) * 67'(c_q);
          default: prod_q[0] <= prod_q[0];
        endcase
      end
      ST_SUM: begin
        tx_q <= 68'(prod_q[0]) + 68'(prod_q[1]);
        ty_q <= 68'(prod_q[2]) - 68'(prod_q[3]);
      end
      ST_OUT: begin
        if (!out_valid_q) begin
          cart_x_q <= (fx > hi_lim) ? FieldBits'(hi_lim) :
                      (fx < lo_lim) ? FieldBits'(lo_lim) : FieldBits'(fx);
          cart_y_q <= (fy > hi_lim) ? FieldBits'(hi_lim) :
                      (fy < lo_lim) ? FieldBits'(lo_lim) : FieldBits'(fy);
          seg_q    <= SegBits'(p_q);
        end
      end
      default: mstep_q <= mstep_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign cart_x_o    = cart_x_q;
  assign cart_y_o    = cart_y_q;
  assign segment_o   = seg_q;

  `F2C_ASSERT(a_idle_ready, clk_i, rst_ni, q_ready_o == (state_q == ST_IDLE),
              "back part ready outside idle")
  `F2C_ASSERT(a_write_load, clk_i, rst_ni, !ram_we || state_q == ST_LOAD,
              "map written outside a load")
  `F2C_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(cart_x_o) && $stable(cart_y_o),
                   "result changed while stalled")

endmodule

@@ hw/rtl/frenet_to_cartesian_unit.sv @@
// ----------------------------------------------------------------------------
// frenet_to_cartesian_unit
// converts road arc and lateral offset to map coordinates over a waypoint map
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: wp_index, wp_arc, wp_east, wp_north, pos_arc, pos_lateral
//                       tuser: action
//  m_axis    out        tdata: cart_x, cart_y, segment
//  cfg       in         map_count
//
//  a load passes through the back part's load state; a convert scans the
//  map entries (one ram read per entry), then runs a 32 step root and two
//  63 step divides, plus up to 30 normalizing shifts; a zero-length segment
//  skips root and divides
//  a two entry queue lets the front accept while the back is busy
//  reset clears control state only; map entries are undefined until loaded
//  a stalled result holds the back part but the queue keeps filling
module frenet_to_cartesian_unit #(
  parameter int unsigned MapDepth  = f2c_pkg::MapDepthDef,
  parameter int unsigned CoordBits = f2c_pkg::CoordBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // wp_index[7:0], wp_arc[39:8], wp_east[71:40], wp_north[103:72],
  // pos_arc[135:104], pos_lateral[167:136]
  input  logic [167:0] s_axis_tdata,
  // action[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cart_x[31:0], cart_y[63:32], segment[71:64]
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [8:0]   cfg_data_i
);
  import f2c_pkg::*;

  logic [CountBits-1:0] map_count_q;
  req_t                 in_req, q_req;
  logic                 q_valid, q_ready;
  logic [FieldBits-1:0] cart_x, cart_y;
  logic [SegBits-1:0]   segment;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_count_q <= CountBits'(1);
    end else if (cfg_valid_i) begin
      map_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    in_req.convert     = (s_axis_tuser == ACT_CONVERT);
    in_req.wp_index    = s_axis_tdata[7:0];
    in_req.wp_arc      = s_axis_tdata[39:8];
    in_req.wp_east     = s_axis_tdata[71:40];
    in_req.wp_north    = s_axis_tdata[103:72];
    in_req.pos_arc     = s_axis_tdata[135:104];
    in_req.pos_lateral = s_axis_tdata[167:136];
  end

  f2c_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_req_i(in_req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req));

  f2c_back #(.MapDepth(MapDepth), .CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .map_count_i(map_count_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cart_x_o(cart_x), .cart_y_o(cart_y), .segment_o(segment));

  assign m_axis_tdata = {segment, cart_y, cart_x};

endmodule
